/* hw/rtl/crosc_pkg.sv */
// ============================================================================
// crosc_pkg: shared types and constants of the complex rotation oscillator
// Widths, Q15 constants, register indexes and phasor types used by the
// rotation datapath, the axis snap logic and the top level.
// ============================================================================
`default_nettype none

package crosc_pkg;

    // Field widths
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 17;
    localparam int Q_SHIFT    = 15;
    localparam int PROD_W     = COEF_W + SAMPLE_W;
    localparam int TERM_W     = PROD_W - Q_SHIFT;
    localparam int SUM_W      = TERM_W + 1;

    // Snap thresholds
    localparam int SNAP_BAND  = 8;
    localparam int FULL_SCALE = 32767;

    // Reset values
    localparam int COEF_REAL_RESET   = 32768;
    localparam int COEF_IMAG_RESET   = 0;
    localparam int PHASOR_REAL_RESET = FULL_SCALE;
    localparam int PHASOR_IMAG_RESET = 0;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] CFG_COEF_REAL = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_COEF_IMAG = 2'd1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [TERM_W-1:0]   term_t;
    typedef logic signed [SUM_W-1:0]    sum_t;

    // Stored phasor, Q15
    typedef struct packed {
        sample_t re;
        sample_t im;
    } phasor_t;

    // Rotated phasor at full precision, before the snap
    typedef struct packed {
        sum_t re;
        sum_t im;
    } wide_phasor_t;

endpackage : crosc_pkg

`default_nettype wire

/* hw/rtl/crosc_rotate.sv */
// ============================================================================
// crosc_rotate: Q15 complex rotation of the stored phasor
// Forms the four coefficient-by-phasor products, floors each by 2^15 and
// combines them into the full-precision rotated phasor.
// ============================================================================
`default_nettype none

module crosc_rotate
    import crosc_pkg::*;
(
    input  coef_t        coef_real,
    input  coef_t        coef_imag,
    input  phasor_t      phasor,
    output wide_phasor_t rotated
);

    sample_t pr;
    sample_t pi;
    prod_t   p_rr;
    prod_t   p_ii;
    prod_t   p_ri;
    prod_t   p_ir;
    term_t   t_rr;
    term_t   t_ii;
    term_t   t_ri;
    term_t   t_ir;

    assign pr = phasor.re;
    assign pi = phasor.im;

    // Form the four signed products
    assign p_rr = coef_real * pr;
    assign p_ii = coef_imag * pi;
    assign p_ri = coef_real * pi;
    assign p_ir = coef_imag * pr;

    // Drop the Q15 fraction bits (floor toward minus infinity)
    assign t_rr = p_rr[PROD_W-1:Q_SHIFT];
    assign t_ii = p_ii[PROD_W-1:Q_SHIFT];
    assign t_ri = p_ri[PROD_W-1:Q_SHIFT];
    assign t_ir = p_ir[PROD_W-1:Q_SHIFT];

    // Combine at full precision
    assign rotated.re = sum_t'(t_rr) - sum_t'(t_ii);
    assign rotated.im = sum_t'(t_ri) + sum_t'(t_ir);

endmodule : crosc_rotate

`default_nettype wire

/* hw/rtl/crosc_snap.sv */
// ============================================================================
// crosc_snap: axis snap of the rotated phasor
// Pulls the phasor onto the real axis, then the imaginary axis, when a
// component nears zero or the other reaches full scale; keeps amplitude.
// ============================================================================
`default_nettype none

module crosc_snap
    import crosc_pkg::*;
(
    input  wide_phasor_t rotated,
    output phasor_t      snapped
);

    localparam sum_t BAND     = sum_t'(SNAP_BAND);
    localparam sum_t NEG_BAND = -BAND;
    localparam sum_t FULL     = sum_t'(FULL_SCALE);
    localparam sum_t NEG_FULL = -FULL;

    sum_t nr1;
    sum_t ni1;
    sum_t nr2;
    sum_t ni2;

    // Snap to the real axis first
    always_comb begin
        nr1 = rotated.re;
        ni1 = rotated.im;
        if ((ni1 > NEG_BAND && ni1 < BAND) || nr1 >= FULL || nr1 <= NEG_FULL) begin
            nr1 = nr1[SUM_W-1] ? NEG_FULL : FULL;
            ni1 = '0;
        end
    end

    // Then snap to the imaginary axis on what is left
    always_comb begin
        nr2 = nr1;
        ni2 = ni1;
        if ((nr2 > NEG_BAND && nr2 < BAND) || ni2 >= FULL || ni2 <= NEG_FULL) begin
            ni2 = ni2[SUM_W-1] ? NEG_FULL : FULL;
            nr2 = '0;
        end
    end

    // Both components now lie within full scale
    assign snapped.re = nr2[SAMPLE_W-1:0];
    assign snapped.im = ni2[SAMPLE_W-1:0];

endmodule : crosc_snap

`default_nettype wire

/* hw/rtl/complex_rotation_oscillator_unit.sv */
// ============================================================================
// complex_rotation_oscillator_unit: Q15 recursive quadrature oscillator
// One sample per input transaction; phasor rotated by a programmable
// complex coefficient, with axis snapping to hold the amplitude.
// ============================================================================
// Each accepted input transaction returns the current phasor as one Q15
// sample (real, imaginary) with batch_end echoed on m_last, and the phasor
// is rotated in the same cycle. The block takes one transaction per clock:
// the feedback path (four 17x16 multiplies, floor by 2^15, one add and the
// axis snap compares) is combinational into the phasor register, and the
// result sits in an output register that accepts a new transaction whenever
// it is empty or being drained. Write coef_real (index 0) and coef_imag
// (index 1) only while no transaction is outstanding; other indexes are
// ignored. After reset the phasor is (32767, 0) and the coefficient is
// (32768, 0).
// ============================================================================
`default_nettype none

module complex_rotation_oscillator_unit
    import crosc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    // Configuration write port
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [COEF_W-1:0]     cfg_wdata,

    // Sample request channel
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_batch_end,

    // Sample result channel
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic signed [SAMPLE_W-1:0] m_sample_real,
    output logic signed [SAMPLE_W-1:0] m_sample_imag,
    output logic                       m_last
);

    coef_t        coef_real_reg;
    coef_t        coef_imag_reg;
    phasor_t      phasor_reg;
    phasor_t      phasor_next;
    wide_phasor_t rotated;
    logic         m_valid_reg;
    sample_t      sample_real_reg;
    sample_t      sample_imag_reg;
    logic         last_reg;
    logic         s_accept;

    // Accept while the output register is empty or being drained
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    crosc_rotate u_rotate (
        .coef_real (coef_real_reg),
        .coef_imag (coef_imag_reg),
        .phasor    (phasor_reg),
        .rotated   (rotated)
    );

    crosc_snap u_snap (
        .rotated (rotated),
        .snapped (phasor_next)
    );

    // Coefficient registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_real_reg <= coef_t'(COEF_REAL_RESET);
            coef_imag_reg <= coef_t'(COEF_IMAG_RESET);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_COEF_REAL: coef_real_reg <= cfg_wdata;
                CFG_COEF_IMAG: coef_imag_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Advance the phasor on each accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phasor_reg.re <= sample_t'(PHASOR_REAL_RESET);
            phasor_reg.im <= sample_t'(PHASOR_IMAG_RESET);
        end else if (s_accept) begin
            phasor_reg <= phasor_next;
        end
    end

    // Output valid: set on accept, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Hold the current sample in the output register
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            sample_real_reg <= phasor_reg.re;
            sample_imag_reg <= phasor_reg.im;
            last_reg        <= s_batch_end;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_sample_real = sample_real_reg;
    assign m_sample_imag = sample_imag_reg;
    assign m_last        = last_reg;

endmodule : complex_rotation_oscillator_unit

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb: self-checking bench for complex_rotation_oscillator_unit
// Drives sample requests with random batch marks and random gaps on both
// channels. Each accepted request is run through a local Q15 rotation
// predictor with its own phasor and coefficient copy. Each returned sample
// is compared field by field against the oldest predicted one. Coefficients
// are reprogrammed between phases while the block is drained, covering the
// unit circle, raw 17-bit patterns and the extreme values.
// ============================================================================

module tb;
    import crosc_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 1700;
    localparam int MAX_REPORTS   = 10;

    // Indexes with no register behind them; writes must be ignored
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED_LO = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED_HI = 2'd3;

    typedef struct {
        sample_t re;
        sample_t im;
        logic    last;
    } osc_sample_t;

    logic                  aclk;
    logic                  aresetn       = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr      = '0;
    logic [COEF_W-1:0]     cfg_wdata     = '0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic                  s_batch_end   = 1'b0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic signed [SAMPLE_W-1:0] m_sample_real;
    logic signed [SAMPLE_W-1:0] m_sample_imag;
    logic                  m_last;

    // Predictor state
    phasor_t     osc_phasor;
    coef_t       rot_coef_re;
    coef_t       rot_coef_im;

    logic        batch_flags[$];
    osc_sample_t sample_queue[$];
    logic        req_taken     = 1'b0;
    int          items_total   = 0;
    int          results_done  = 0;
    int          mismatches    = 0;
    int          cycle_count   = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    complex_rotation_oscillator_unit uut (
        .aclk,
        .aresetn,
        .cfg_wr_en,
        .cfg_addr,
        .cfg_wdata,
        .s_valid,
        .s_ready,
        .s_batch_end,
        .m_valid,
        .m_ready,
        .m_sample_real,
        .m_sample_imag,
        .m_last
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // One step of the oscillator: rotate by the coefficient, floor each
    // product by 2^15, then snap to the real axis first and the imaginary
    // axis second.
    function automatic phasor_t rotate_phasor(phasor_t p, coef_t cr, coef_t ci);
        longint  pr;
        longint  pim;
        longint  c_re;
        longint  c_im;
        longint  nr;
        longint  ni;
        phasor_t n;
        pr   = p.re;
        pim  = p.im;
        c_re = cr;
        c_im = ci;
        nr = ((c_re * pr) >>> Q_SHIFT) - ((c_im * pim) >>> Q_SHIFT);
        ni = ((c_re * pim) >>> Q_SHIFT) + ((c_im * pr) >>> Q_SHIFT);
        if ((ni > -SNAP_BAND && ni < SNAP_BAND) || nr >= FULL_SCALE || nr <= -FULL_SCALE) begin
            nr = (nr >= 0) ? FULL_SCALE : -FULL_SCALE;
            ni = 0;
        end
        if ((nr > -SNAP_BAND && nr < SNAP_BAND) || ni >= FULL_SCALE || ni <= -FULL_SCALE) begin
            ni = (ni >= 0) ? FULL_SCALE : -FULL_SCALE;
            nr = 0;
        end
        n.re = sample_t'(nr);
        n.im = sample_t'(ni);
        return n;
    endfunction

    // Request driver: hold an unaccepted transaction, else issue or idle
    always @(negedge aclk) begin
        if (s_valid && !req_taken) begin
            // hold payload until accepted
        end else if (aresetn && batch_flags.size() != 0
                     && $urandom_range(99) >= send_idle_pct) begin
            s_valid     <= 1'b1;
            s_batch_end <= batch_flags.pop_front();
        end else begin
            s_valid     <= 1'b0;
            s_batch_end <= 1'($urandom_range(1));
        end
    end

    // Result side backpressure
    always @(negedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
    end

    // Check returned samples first, then predict for a newly accepted request
    always @(posedge aclk) begin : sample_check
        osc_sample_t want;
        req_taken <= aresetn && s_valid && s_ready;
        if (aresetn && m_valid && m_ready) begin
            if (sample_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected sample re=%0d im=%0d last=%0b",
                             $time, m_sample_real, m_sample_imag, m_last);
            end else begin
                want = sample_queue.pop_front();
                results_done++;
                if (m_sample_real !== want.re || m_sample_imag !== want.im
                    || m_last !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: sample mismatch, expected re=%0d im=%0d last=%0b, got re=%0d im=%0d last=%0b",
                                 $time, want.re, want.im, want.last,
                                 m_sample_real, m_sample_imag, m_last);
                end
            end
        end
        if (aresetn && s_valid && s_ready) begin
            want.re   = osc_phasor.re;
            want.im   = osc_phasor.im;
            want.last = s_batch_end;
            sample_queue.push_back(want);
            osc_phasor = rotate_phasor(osc_phasor, rot_coef_re, rot_coef_im);
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Write one configuration register; the block must be drained
    task automatic program_reg(input logic [CFG_ADDR_W-1:0] idx,
                               input logic [COEF_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        if (idx == CFG_COEF_REAL)
            rot_coef_re = value;
        else if (idx == CFG_COEF_IMAG)
            rot_coef_im = value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Queue a batch of requests, then pause until every sample is back
    task automatic run_batch(input int count);
        for (int i = 0; i < count; i++)
            batch_flags.push_back(i == count - 1 || $urandom_range(7) == 0);
        items_total += count;
        while (results_done != items_total)
            @(negedge aclk);
    endtask

    task automatic program_coef(input int re_val, input int im_val);
        program_reg(CFG_COEF_REAL, COEF_W'(re_val));
        program_reg(CFG_COEF_IMAG, COEF_W'(im_val));
    endtask

    initial begin
        int  coef_edges[5];
        int  random_sent;
        int  batch_len;
        int  kind;
        int  c_re;
        int  c_im;
        coef_edges    = '{-65536, -32768, 0, 32768, 65535};
        random_sent   = 0;
        osc_phasor.re = sample_t'(PHASOR_REAL_RESET);
        osc_phasor.im = sample_t'(PHASOR_IMAG_RESET);
        rot_coef_re   = coef_t'(COEF_REAL_RESET);
        rot_coef_im   = coef_t'(COEF_IMAG_RESET);
        send_idle_pct = 19;
        recv_idle_pct = 67;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset coefficient: identity rotation, phasor pinned at full scale
        run_batch(3);
        // Writes to unused indexes leave the coefficient alone
        program_reg(CFG_UNUSED_LO, 17'h1FFFF);
        program_reg(CFG_UNUSED_HI, 17'h10000);
        run_batch(2);
        // Quarter turn: walk the phasor around all four axis points
        program_coef(0, 32768);
        run_batch(5);
        // Out-of-range extremes drive both components to full scale snaps
        program_coef(-65536, 65535);
        run_batch(3);
        program_coef(65535, -65536);
        run_batch(2);
        // Eighth turn and a small step, away from the axes
        program_coef(23170, 23170);
        run_batch(4);
        program_coef(32760, -600);
        run_batch(4);

        // Random phases, each with a fresh coefficient
        while (random_sent < RANDOM_ITEMS) begin
            if (random_sent < RANDOM_ITEMS / 3) begin
                send_idle_pct = 19;
                recv_idle_pct = 67;
            end else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 67;
                recv_idle_pct = 19;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            kind = $urandom_range(9);
            if (kind < 6) begin
                // near the unit circle, as a real frequency setting gives
                c_re = int'($urandom_range(65536)) - 32768;
                c_im = $rtoi($sqrt(32768.0 * 32768.0 - real'(c_re) * real'(c_re)));
                if ($urandom_range(1) == 1)
                    c_im = -c_im;
            end else if (kind < 8) begin
                c_re = int'($urandom() & 32'h1FFFF);
                c_im = int'($urandom() & 32'h1FFFF);
            end else begin
                c_re = coef_edges[$urandom_range(4)];
                c_im = coef_edges[$urandom_range(4)];
            end
            program_coef(c_re, c_im);
            if ($urandom_range(7) == 0)
                program_reg($urandom_range(1) ? CFG_UNUSED_LO : CFG_UNUSED_HI,
                            COEF_W'($urandom()));
            batch_len = $urandom_range(20, 120);
            run_batch(batch_len);
            random_sent += batch_len;
        end

        // Let any stray late result show up before the verdict
        repeat (8) @(posedge aclk);
        mismatches += sample_queue.size();
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/crosc_pkg.sv
hw/rtl/crosc_rotate.sv
hw/rtl/crosc_snap.sv
hw/rtl/complex_rotation_oscillator_unit.sv
test/tb.sv
